// File: rtl/mlfs_pkg.sv
package mlfs_pkg;

    localparam int MAX_RESULTS = 5;
    localparam int CNT_W       = 3;

    localparam logic [7:0] CMD_WRITE  = 8'h80;
    localparam logic [7:0] CMD_CLEAR  = 8'h04;
    localparam int         VCOM_SHIFT = 6;
    localparam logic [7:0] PAD_BYTE   = 8'h00;

    localparam logic [4:0] ROW_BYTES_RESET   = 5'd16;
    localparam logic [7:0] LINE_COUNT_RESET  = 8'd128;
    localparam logic       VCOM_BY_PIN_RESET = 1'b1;

    typedef enum logic [1:0] {
        REG_ROW_BYTES   = 2'd0,
        REG_LINE_COUNT  = 2'd1,
        REG_VCOM_BY_PIN = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        ACT_PIXEL  = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_TOGGLE = 2'd2
    } action_t;

    typedef enum logic {
        KIND_SPI_BYTE = 1'b0,
        KIND_VCOM_PIN = 1'b1
    } kind_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic       select_start;
        logic       select_end;
        logic       vcom_level;
        logic       last;
    } result_t;

    // words caused by one accepted input word, entry 0 goes out first
    typedef struct packed {
        logic [CNT_W-1:0]             cnt;
        result_t [MAX_RESULTS-1:0]    ent;
    } plan_t;

    function automatic logic [7:0] bit_reverse(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

endpackage

// File: rtl/mlfs_in_if.sv
interface mlfs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] pixel_byte;

    modport source (output valid, output action, output pixel_byte, input ready);
    modport sink   (input valid, input action, input pixel_byte, output ready);
endinterface

// File: rtl/mlfs_out_if.sv
interface mlfs_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] out_byte;
    logic       select_start;
    logic       select_end;
    logic       vcom_level;
    logic       last;

    modport source (output valid, output kind, output out_byte, output select_start,
                    output select_end, output vcom_level, output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input select_start,
                    input select_end, input vcom_level, input last, output ready);
endinterface

// File: rtl/mlfs_frame_ctrl.sv
module mlfs_frame_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    mlfs_in_if.sink           in_ch,
    input  logic              space_ok,
    output mlfs_pkg::plan_t   plan,
    output logic              plan_load
);

    logic [4:0] row_bytes_reg;
    logic [7:0] line_count_reg;
    logic       vcom_by_pin_reg;

    logic       vcom_reg,       vcom_next;
    logic [7:0] line_index_reg, line_index_next;
    logic [4:0] byte_index_reg, byte_index_next;

    logic accept;

    assign in_ch.ready = space_ok;
    assign accept      = in_ch.valid && space_ok;
    assign plan_load   = accept && (plan.cnt != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg   <= mlfs_pkg::ROW_BYTES_RESET;
            line_count_reg  <= mlfs_pkg::LINE_COUNT_RESET;
            vcom_by_pin_reg <= mlfs_pkg::VCOM_BY_PIN_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                mlfs_pkg::REG_ROW_BYTES:   row_bytes_reg   <= cfg_data[4:0];
                mlfs_pkg::REG_LINE_COUNT:  line_count_reg  <= cfg_data;
                mlfs_pkg::REG_VCOM_BY_PIN: vcom_by_pin_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcom_reg       <= 1'b0;
            line_index_reg <= '0;
            byte_index_reg <= '0;
        end
        else if (accept)
        begin
            vcom_reg       <= vcom_next;
            line_index_reg <= line_index_next;
            byte_index_reg <= byte_index_next;
        end
    end

    always_comb
    begin
        logic [4:0]                   rb;
        logic [7:0]                   lc;
        logic [7:0]                   li;
        logic [4:0]                   bi;
        logic [4:0]                   bi1;
        logic                         line_done;
        logic [7:0]                   vbyte;
        logic [mlfs_pkg::CNT_W-1:0]   n;
        mlfs_pkg::result_t            blank;

        rb = (row_bytes_reg == '0) ? 5'd1 : row_bytes_reg;
        lc = (line_count_reg == '0) ? 8'd1 : line_count_reg;

        vcom_next       = vcom_reg;
        line_index_next = line_index_reg;
        byte_index_next = byte_index_reg;

        li        = (line_index_reg == '0) ? 8'd1 : line_index_reg;
        bi        = (line_index_reg == '0) ? 5'd0 : byte_index_reg;
        bi1       = bi + 5'd1;
        line_done = (bi1 == '0) || (bi1 >= rb);

        blank      = '0;
        plan.ent   = '0;
        n          = '0;

        case (in_ch.action)
            mlfs_pkg::ACT_PIXEL:
            begin
                vbyte = 8'(vcom_reg) << mlfs_pkg::VCOM_SHIFT;
                if (line_index_reg == '0)
                begin
                    plan.ent[n]              = blank;
                    plan.ent[n].out_byte     = mlfs_pkg::CMD_WRITE | vbyte;
                    plan.ent[n].select_start = 1'b1;
                    n = n + 3'd1;
                end
                if (bi == '0)
                begin
                    plan.ent[n]          = blank;
                    plan.ent[n].out_byte = mlfs_pkg::bit_reverse(li);
                    n = n + 3'd1;
                end
                plan.ent[n]          = blank;
                plan.ent[n].out_byte = in_ch.pixel_byte;
                n = n + 3'd1;
                byte_index_next = bi1;
                line_index_next = li;
                if (line_done)
                begin
                    // trailing pad of the line
                    plan.ent[n]          = blank;
                    plan.ent[n].out_byte = mlfs_pkg::PAD_BYTE;
                    n = n + 3'd1;
                    byte_index_next = '0;
                    if (li >= lc)
                    begin
                        // frame trailer releases chip select
                        plan.ent[n]            = blank;
                        plan.ent[n].out_byte   = mlfs_pkg::PAD_BYTE;
                        plan.ent[n].select_end = 1'b1;
                        n = n + 3'd1;
                        line_index_next = '0;
                    end
                    else
                    begin
                        line_index_next = li + 8'd1;
                    end
                end
            end
            mlfs_pkg::ACT_CLEAR:
            begin
                vbyte = 8'(vcom_reg) << mlfs_pkg::VCOM_SHIFT;
                if (line_index_reg == '0)
                begin
                    plan.ent[0].out_byte     = mlfs_pkg::CMD_CLEAR | vbyte;
                    plan.ent[0].select_start = 1'b1;
                    plan.ent[1].out_byte     = mlfs_pkg::PAD_BYTE;
                    plan.ent[1].select_end   = 1'b1;
                    n = 3'd2;
                end
            end
            mlfs_pkg::ACT_TOGGLE:
            begin
                vbyte = {7'd0, ~vcom_reg} << mlfs_pkg::VCOM_SHIFT;
                if (line_index_reg == '0)
                begin
                    vcom_next = ~vcom_reg;
                    if (vcom_by_pin_reg)
                    begin
                        plan.ent[0].kind = mlfs_pkg::KIND_VCOM_PIN;
                        n = 3'd1;
                    end
                    else
                    begin
                        plan.ent[0].out_byte     = vbyte;
                        plan.ent[0].select_start = 1'b1;
                        plan.ent[1].out_byte     = mlfs_pkg::PAD_BYTE;
                        plan.ent[1].select_end   = 1'b1;
                        n = 3'd2;
                    end
                end
            end
            default:
            begin
                vbyte = '0;
            end
        endcase

        for (int i = 0; i < mlfs_pkg::MAX_RESULTS; i++)
        begin
            plan.ent[i].vcom_level = vcom_next;
            plan.ent[i].last       = (n != '0) && (3'(i + 1) == n);
        end
        plan.cnt = n;
    end

endmodule

// File: rtl/mlfs_out_queue.sv
module mlfs_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  mlfs_pkg::plan_t   plan,
    input  logic              plan_load,
    output logic              space_ok,
    mlfs_out_if.source        out_ch
);

    mlfs_pkg::result_t [mlfs_pkg::MAX_RESULTS-1:0] ent_reg, ent_next;
    logic [mlfs_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic pop;

    assign pop      = out_ch.valid && out_ch.ready;
    assign space_ok = (cnt_reg == '0) || ((cnt_reg == 3'd1) && out_ch.ready);

    assign out_ch.valid        = (cnt_reg != '0);
    assign out_ch.kind         = ent_reg[0].kind;
    assign out_ch.out_byte     = ent_reg[0].out_byte;
    assign out_ch.select_start = ent_reg[0].select_start;
    assign out_ch.select_end   = ent_reg[0].select_end;
    assign out_ch.vcom_level   = ent_reg[0].vcom_level;
    assign out_ch.last         = ent_reg[0].last;

    always_comb
    begin
        ent_next = ent_reg;
        cnt_next = cnt_reg;
        if (plan_load)
        begin
            ent_next = plan.ent;
            cnt_next = plan.cnt;
        end
        else if (pop)
        begin
            for (int i = 0; i < mlfs_pkg::MAX_RESULTS - 1; i++)
            begin
                ent_next[i] = ent_reg[i+1];
            end
            ent_next[mlfs_pkg::MAX_RESULTS-1] = '0;
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

`ifndef SYNTH
    a_load_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        plan_load |-> (cnt_reg == '0) || ((cnt_reg == 3'd1) && pop))
        else $error("queue reloaded while words still pending");

    a_pop_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !plan_load) |=> (cnt_reg == $past(cnt_reg) - 3'd1))
        else $error("pending count did not drop after a pop");

    a_last_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.last) |-> (cnt_reg == 3'd1))
        else $error("last word shown with more words behind it");
`endif

endmodule

// File: rtl/memory_lcd_frame_serializer.sv
// memory LCD frame serializer: takes input words (pixel byte, clear, toggle vcom) and
// emits the SPI word stream of a memory LCD, one output word per cycle while out_ch
// is ready, with chip select start/end marks and vcom pin events. each input word is
// decoded combinationally into up to five output words held in a small output queue;
// the queue drains one word per cycle while out_ch is ready and takes the next input
// word in the same cycle its final word is taken. a pixel byte in the middle of a line
// thus passes at one word per cycle when not stalled; a word that opens a frame or a
// line, closes a line or closes a frame adds one output word for each such event
// (command, line address, line pad, frame pad) that must drain first. clear and toggle
// are ignored while a frame is open, as are undefined action codes. zero row byte or
// line count acts as one. registers are written through cfg_write_en/cfg_index/
// cfg_data only while the block is idle, a rule for the user not enforced by the block.
module memory_lcd_frame_serializer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    mlfs_in_if.sink     in_ch,
    mlfs_out_if.source  out_ch
);

    // decoded words of the accepted input word
    mlfs_pkg::plan_t plan;
    logic            plan_load;
    // queue can take a new word this cycle
    logic            space_ok;

    // frame position, vcom bit and config registers, decode into a word plan
    mlfs_frame_ctrl u_frame_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_ch        (in_ch),
        .space_ok     (space_ok),
        .plan         (plan),
        .plan_load    (plan_load)
    );

    // result register bank, shifts one word out per cycle while out_ch is ready
    mlfs_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .plan      (plan),
        .plan_load (plan_load),
        .space_ok  (space_ok),
        .out_ch    (out_ch)
    );

endmodule
